// File: design/fan_tach_rpm_lockout_switch_core_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the fan tach RPM lockout switch
// Shared concurrent assertion forms used by the port checker.
// ----------------------------------------------------------------------------
`ifndef FAN_TACH_RPM_LOCKOUT_SWITCH_CORE_ASSERT_SVH
`define FAN_TACH_RPM_LOCKOUT_SWITCH_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define FTRLS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("ftrls assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define FTRLS_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("ftrls assertion failed");

`endif

// File: design/ftrls_pkg.sv
// ----------------------------------------------------------------------------
// ftrls_pkg
// Types and constants shared by the fan tach RPM lockout switch modules.
// ----------------------------------------------------------------------------
`default_nettype none

package ftrls_pkg;

  localparam int unsigned FAN_COUNT_DEF     = 2;
  localparam int unsigned WINDOW_LENGTH_DEF = 50;

  localparam int unsigned CNT_W   = 16;
  localparam int unsigned RPM_W   = 16;
  localparam int unsigned TICK_W  = 32;
  localparam int unsigned PROD_W  = 23;

  localparam logic [6:0]        RPM_PER_COUNT     = 7'd120;
  localparam logic [RPM_W-1:0]  RPM_MAX           = 16'hFFFF;
  localparam logic [TICK_W-1:0] RESET_LOCKOUT_END = 32'd1200;

  typedef enum logic [1:0] {
    OP_SAMPLE  = 2'd0,
    OP_TICK    = 2'd1,
    OP_CONTROL = 2'd2
  } op_e;

  typedef enum logic [2:0] {
    ACT_NONE   = 3'd0,
    ACT_ON     = 3'd1,
    ACT_OFF    = 3'd2,
    ACT_IDLE   = 3'd3,
    ACT_LOCKED = 3'd4
  } act_e;

  typedef enum logic [1:0] {
    REG_ON_THR   = 2'd0,
    REG_OFF_THR  = 2'd1,
    REG_LOCK_LEN = 2'd2
  } reg_e;

  typedef struct packed {
    logic sample;
    logic window_end;
  } lane_ctl_t;

  typedef struct packed {
    logic tick;
    logic control;
  } sw_ctl_t;

  typedef struct packed {
    logic [RPM_W-1:0] on_thr;
    logic [RPM_W-1:0] off_thr;
    logic [RPM_W-1:0] lock_len;
  } cfg_t;

endpackage

`default_nettype wire

// File: design/fan_tach_rpm_lockout_switch_core.sv
// ----------------------------------------------------------------------------
// fan_tach_rpm_lockout_switch_core
// Fan tachometer RPM counter with a lockout-protected output switch.
// ----------------------------------------------------------------------------
// Events arrive on the slave stream: tuser carries the event kind (pin
// sample, timer tick or control pass) and tdata the two tach pin levels.
// Each accepted transaction yields exactly one result transaction on the
// master stream, carrying the switch state, the lockout flag, both latched
// RPM values and the action taken, all as they stand after the event.
// Thresholds and the lockout length are written through the APB port; they
// should only be changed while no transaction is in flight.
// An accepted event waits in the input register and is processed as it
// leaves it, where all state is updated and the result register loaded;
// tvalid on the master side rises once the result register holds it.
// One transaction per cycle is sustained while the receiver takes
// results; the rate is set by the single state-update stage between
// the input and result registers.
// When the receiver stalls, the result register holds its transaction and
// one further event waits in the input register; tready then drops until
// the result is taken. Reset clears both stages, the edge counters and RPM
// values, and starts with a lockout in force until tick 1200.
// ----------------------------------------------------------------------------
`default_nettype none

module fan_tach_rpm_lockout_switch_core #(
  parameter int unsigned FAN_COUNT     = ftrls_pkg::FAN_COUNT_DEF,
  parameter int unsigned WINDOW_LENGTH = ftrls_pkg::WINDOW_LENGTH_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // APB configuration port
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready,
  // Event stream in
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,  // [0] tach1_level, [1] tach2_level, rest zero
  input  wire logic [1:0]  s_axis_tuser,  // [1:0] op
  // Result stream out
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // [0] output_state, [1] locked_out, [17:2] fan1_rpm, [33:18] fan2_rpm,
  // [36:34] action, rest zero
  output logic      [39:0] m_axis_tdata
);

  localparam int unsigned WIN_W = $clog2(WINDOW_LENGTH + 1);

  // Configuration registers.
  ftrls_pkg::cfg_t cfg_q;
  logic            cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_wr) begin
      unique case (ftrls_pkg::reg_e'(paddr[3:2]))
        ftrls_pkg::REG_ON_THR:   cfg_q.on_thr   <= pwdata[15:0];
        ftrls_pkg::REG_OFF_THR:  cfg_q.off_thr  <= pwdata[15:0];
        ftrls_pkg::REG_LOCK_LEN: cfg_q.lock_len <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (ftrls_pkg::reg_e'(paddr[3:2]))
      ftrls_pkg::REG_ON_THR:   prdata = {16'h0, cfg_q.on_thr};
      ftrls_pkg::REG_OFF_THR:  prdata = {16'h0, cfg_q.off_thr};
      ftrls_pkg::REG_LOCK_LEN: prdata = {16'h0, cfg_q.lock_len};
      default:                 prdata = '0;
    endcase
  end

  // Input register. It refills in the same cycle that its event moves on.
  logic       in_valid_q;
  logic [1:0] op_q;
  logic [1:0] level_q;
  logic       advance;
  logic       out_valid_q;

  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      op_q    <= s_axis_tuser;
      level_q <= s_axis_tdata[1:0];
    end
  end

  // Event decode; state only moves when the event leaves the input register.
  logic is_sample, is_tick, is_control;

  always_comb begin
    is_sample  = 1'b0;
    is_tick    = 1'b0;
    is_control = 1'b0;
    case (ftrls_pkg::op_e'(op_q))
      ftrls_pkg::OP_SAMPLE:  is_sample  = advance;
      ftrls_pkg::OP_TICK:    is_tick    = advance;
      ftrls_pkg::OP_CONTROL: is_control = advance;
      default: ;
    endcase
  end

  // Measurement window: the RPM values are latched on every WINDOW_LENGTH-th tick.
  logic [WIN_W-1:0] window_q, window_d;
  logic             window_end;

  assign window_end = is_tick && (window_q >= WIN_W'(WINDOW_LENGTH - 1));

  always_comb begin
    window_d = window_q;
    if (window_end) begin
      window_d = '0;
    end else if (is_tick) begin
      window_d = window_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_q <= '0;
    end else begin
      window_q <= window_d;
    end
  end

  // One counting lane per fan; fans beyond the second see a low tach line.
  ftrls_pkg::lane_ctl_t        lane_ctl;
  logic [ftrls_pkg::RPM_W-1:0] rpm     [FAN_COUNT];
  logic [ftrls_pkg::RPM_W-1:0] rpm_next[FAN_COUNT];

  assign lane_ctl.sample     = is_sample;
  assign lane_ctl.window_end = window_end;

  for (genvar g = 0; g < FAN_COUNT; g++) begin : g_lane
    logic lane_level;
    if (g < 2) begin : g_pin
      assign lane_level = level_q[g];
    end else begin : g_tied
      assign lane_level = 1'b0;
    end
    ftrls_tach_lane u_lane (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctl_i      (lane_ctl),
      .level_i    (lane_level),
      .rpm_o      (rpm[g]),
      .rpm_next_o (rpm_next[g])
    );
  end

  // Switch and lockout control.
  ftrls_pkg::sw_ctl_t sw_ctl;
  logic               switch_next;
  logic               locked_next;
  ftrls_pkg::act_e    action;

  assign sw_ctl.tick    = is_tick;
  assign sw_ctl.control = is_control;

  ftrls_switch_ctrl u_switch (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .ctl_i            (sw_ctl),
    .cfg_i            (cfg_q),
    .rpm_i            (rpm[0]),
    .switch_on_next_o (switch_next),
    .locked_next_o    (locked_next),
    .action_o         (action)
  );

  // Result register.
  logic [ftrls_pkg::RPM_W-1:0] fan2_next;
  logic                        res_switch_q;
  logic                        res_locked_q;
  logic [ftrls_pkg::RPM_W-1:0] res_fan1_q;
  logic [ftrls_pkg::RPM_W-1:0] res_fan2_q;
  ftrls_pkg::act_e             res_action_q;

  if (FAN_COUNT > 1) begin : g_fan2
    assign fan2_next = rpm_next[1];
  end else begin : g_no_fan2
    assign fan2_next = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_switch_q <= switch_next;
      res_locked_q <= locked_next;
      res_fan1_q   <= rpm_next[0];
      res_fan2_q   <= fan2_next;
      res_action_q <= action;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {3'b000, res_action_q, res_fan2_q, res_fan1_q,
                          res_locked_q, res_switch_q};

endmodule

`default_nettype wire

// File: design/ftrls_tach_lane.sv
// ----------------------------------------------------------------------------
// ftrls_tach_lane
// Rising-edge counter and RPM latch for one fan tach line.
// ----------------------------------------------------------------------------
`default_nettype none

module ftrls_tach_lane (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire ftrls_pkg::lane_ctl_t         ctl_i,
  input  wire logic                         level_i,
  output logic [ftrls_pkg::RPM_W-1:0]       rpm_o,
  output logic [ftrls_pkg::RPM_W-1:0]       rpm_next_o
);

  logic                             prev_q, prev_d;
  logic [ftrls_pkg::CNT_W-1:0]      count_q, count_d;
  logic [ftrls_pkg::RPM_W-1:0]      rpm_q, rpm_d;
  logic [ftrls_pkg::PROD_W-1:0]     product;

  assign product = ftrls_pkg::PROD_W'(count_q) * ftrls_pkg::PROD_W'(ftrls_pkg::RPM_PER_COUNT);

  always_comb begin
    prev_d  = prev_q;
    count_d = count_q;
    rpm_d   = rpm_q;
    if (ctl_i.sample) begin
      if (!prev_q && level_i) begin
        count_d = count_q + 1'b1;
      end
      prev_d = level_i;
    end
    if (ctl_i.window_end) begin
      // Saturate when the product does not fit the RPM field.
      rpm_d   = (product[ftrls_pkg::PROD_W-1:ftrls_pkg::RPM_W] != '0) ?
                ftrls_pkg::RPM_MAX : product[ftrls_pkg::RPM_W-1:0];
      count_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q  <= 1'b0;
      count_q <= '0;
      rpm_q   <= '0;
    end else begin
      prev_q  <= prev_d;
      count_q <= count_d;
      rpm_q   <= rpm_d;
    end
  end

  assign rpm_o      = rpm_q;
  assign rpm_next_o = rpm_d;

endmodule

`default_nettype wire

// File: design/ftrls_switch_ctrl.sv
// ----------------------------------------------------------------------------
// ftrls_switch_ctrl
// Tick counter, lockout timer and hysteresis switch driven by fan 1 RPM.
// ----------------------------------------------------------------------------
`default_nettype none

module ftrls_switch_ctrl (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire ftrls_pkg::sw_ctl_t           ctl_i,
  input  wire ftrls_pkg::cfg_t              cfg_i,
  input  wire logic [ftrls_pkg::RPM_W-1:0]  rpm_i,
  output logic                              switch_on_next_o,
  output logic                              locked_next_o,
  output ftrls_pkg::act_e                   action_o
);

  logic [ftrls_pkg::TICK_W-1:0] tick_q, tick_d;
  logic [ftrls_pkg::TICK_W-1:0] lock_end_q, lock_end_d;
  logic                         locked_q, locked_d;
  logic                         switch_q, switch_d;
  logic [ftrls_pkg::TICK_W-1:0] remaining;

  assign remaining = lock_end_q - tick_q;

  always_comb begin
    tick_d     = tick_q;
    lock_end_d = lock_end_q;
    locked_d   = locked_q;
    switch_d   = switch_q;
    action_o   = ftrls_pkg::ACT_NONE;
    if (ctl_i.tick) begin
      tick_d = tick_q + 1'b1;
    end
    if (ctl_i.control) begin
      if (!locked_q) begin
        if (!switch_q && (rpm_i > cfg_i.on_thr)) begin
          switch_d   = 1'b1;
          locked_d   = 1'b1;
          lock_end_d = tick_q + ftrls_pkg::TICK_W'(cfg_i.lock_len);
          action_o   = ftrls_pkg::ACT_ON;
        end else if (switch_q && (rpm_i < cfg_i.off_thr)) begin
          switch_d   = 1'b0;
          locked_d   = 1'b1;
          lock_end_d = tick_q + ftrls_pkg::TICK_W'(cfg_i.lock_len);
          action_o   = ftrls_pkg::ACT_OFF;
        end else begin
          action_o = ftrls_pkg::ACT_IDLE;
        end
      end else begin
        // The lockout is over once the end tick is reached or passed.
        if ((remaining == '0) || remaining[ftrls_pkg::TICK_W-1]) begin
          locked_d = 1'b0;
        end
        action_o = ftrls_pkg::ACT_LOCKED;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_q     <= '0;
      lock_end_q <= ftrls_pkg::RESET_LOCKOUT_END;
      locked_q   <= 1'b1;
      switch_q   <= 1'b0;
    end else begin
      tick_q     <= tick_d;
      lock_end_q <= lock_end_d;
      locked_q   <= locked_d;
      switch_q   <= switch_d;
    end
  end

  assign switch_on_next_o = switch_d;
  assign locked_next_o    = locked_d;

endmodule

`default_nettype wire

// File: design/ftrls_checker.sv
// ----------------------------------------------------------------------------
// ftrls_checker
// Port-level checks of the fan tach RPM lockout switch, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "fan_tach_rpm_lockout_switch_core_assert.svh"

module ftrls_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        psel,
  input wire logic        penable,
  input wire logic        pwrite,
  input wire logic [3:0]  paddr,
  input wire logic [31:0] pwdata,
  input wire logic [31:0] prdata,
  input wire logic        pready,
  input wire logic        s_axis_tvalid,
  input wire logic        s_axis_tready,
  input wire logic [7:0]  s_axis_tdata,
  input wire logic [1:0]  s_axis_tuser,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [39:0] m_axis_tdata
);

  logic       out_switch;
  logic       out_locked;
  logic [2:0] out_action;

  assign out_switch = m_axis_tdata[0];
  assign out_locked = m_axis_tdata[1];
  assign out_action = m_axis_tdata[36:34];

  // A stalled result stays offered.
  `FTRLS_ASSERT_NXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)

  // With no result waiting, the block always takes a new event.
  `FTRLS_ASSERT_IMP(a_ready_when_empty, clk_i, rst_ni, !m_axis_tvalid, s_axis_tready)

  // A switch change always lands in the new state with a lockout started.
  `FTRLS_ASSERT_IMP(a_switch_change, clk_i, rst_ni,
                    m_axis_tvalid && ((out_action == ftrls_pkg::ACT_ON) ||
                                      (out_action == ftrls_pkg::ACT_OFF)),
                    out_locked && (out_switch == (out_action == ftrls_pkg::ACT_ON)))

  // An evaluation with nothing to do happens only outside a lockout.
  `FTRLS_ASSERT_IMP(a_idle_unlocked, clk_i, rst_ni,
                    m_axis_tvalid && (out_action == ftrls_pkg::ACT_IDLE), !out_locked)

endmodule

bind fan_tach_rpm_lockout_switch_core ftrls_checker u_ftrls_checker (.*);

`default_nettype wire

// File: tb/fan_tach_rpm_lockout_switch_core_check.sv
// ----------------------------------------------------------------------------
// Fan tach RPM lockout switch: stream and register observer
// Follows every accepted event and register write, works out the report
// each event must produce and compares it with the result stream.
// ----------------------------------------------------------------------------
module fan_tach_rpm_lockout_switch_core_check (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,  // [0] tach1_level, [1] tach2_level, rest zero
  input  logic [1:0]  s_axis_tuser,  // [1:0] op
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [0] output_state, [1] locked_out, [17:2] fan1_rpm, [33:18] fan2_rpm,
  // [36:34] action, rest zero
  input  logic [39:0] m_axis_tdata,
  output int unsigned pending_o,
  output int unsigned mismatches_o
);
  timeunit 1ns;
  timeprecision 1ps;

  import ftrls_pkg::*;

  typedef struct {
    logic             output_state;
    logic             locked_out;
    logic [RPM_W-1:0] fan1_rpm;
    logic [RPM_W-1:0] fan2_rpm;
    act_e             action;
  } switch_report_t;

  // Shadow of the block's registers and state.
  cfg_t              cfg;
  logic [1:0]        tach_prev;
  logic [CNT_W-1:0]  edge_cnt [2];
  logic [RPM_W-1:0]  rpm [2];
  logic [7:0]        window_pos;
  logic [TICK_W-1:0] ticks_seen;
  logic [TICK_W-1:0] lock_until;
  logic              locked;
  logic              switched_on;
  switch_report_t    awaited_reports [$];

  // Applies one event to the shadow state and returns the report it yields.
  function automatic switch_report_t apply_event(logic [1:0] op, logic [1:0] levels);
    switch_report_t rep;
    logic [31:0]    prod;
    logic [31:0]    gap;
    act_e           act;
    act = ACT_NONE;
    case (op)
      OP_SAMPLE: begin
        for (int i = 0; i < 2; i++) begin
          if (!tach_prev[i] && levels[i]) edge_cnt[i] = edge_cnt[i] + 1'b1;
          tach_prev[i] = levels[i];
        end
      end
      OP_TICK: begin
        ticks_seen = ticks_seen + 1'b1;
        window_pos = window_pos + 1'b1;
        if (window_pos >= WINDOW_LENGTH_DEF) begin
          for (int i = 0; i < 2; i++) begin
            prod   = 32'(edge_cnt[i]) * 32'(RPM_PER_COUNT);
            rpm[i] = (prod > 32'(RPM_MAX)) ? RPM_MAX : prod[RPM_W-1:0];
            edge_cnt[i] = '0;
          end
          window_pos = '0;
        end
      end
      OP_CONTROL: begin
        if (!locked) begin
          if (!switched_on && rpm[0] > cfg.on_thr) begin
            switched_on = 1'b1;
            locked      = 1'b1;
            lock_until  = ticks_seen + 32'(cfg.lock_len);
            act         = ACT_ON;
          end else if (switched_on && rpm[0] < cfg.off_thr) begin
            switched_on = 1'b0;
            locked      = 1'b1;
            lock_until  = ticks_seen + 32'(cfg.lock_len);
            act         = ACT_OFF;
          end else begin
            act = ACT_IDLE;
          end
        end else begin
          // The lockout is over once the remaining distance, read as signed, is not positive.
          gap = lock_until - ticks_seen;
          if (gap == '0 || gap[31]) locked = 1'b0;
          act = ACT_LOCKED;
        end
      end
      default: ;
    endcase
    rep.output_state = switched_on;
    rep.locked_out   = locked;
    rep.fan1_rpm     = rpm[0];
    rep.fan2_rpm     = rpm[1];
    rep.action       = act;
    return rep;
  endfunction

  function automatic void compare_field(string name, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches_o++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    switch_report_t want;
    if (!rst_ni) begin
      cfg         = '0;
      tach_prev   = '0;
      edge_cnt[0] = '0;
      edge_cnt[1] = '0;
      rpm[0]      = '0;
      rpm[1]      = '0;
      window_pos  = '0;
      ticks_seen  = '0;
      lock_until  = RESET_LOCKOUT_END;
      locked      = 1'b1;
      switched_on = 1'b0;
      awaited_reports.delete();
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (awaited_reports.size() == 0) begin
          $error("result transaction arrived with no event waiting for it");
          mismatches_o++;
        end else begin
          want = awaited_reports.pop_front();
          compare_field("output_state", 16'(want.output_state), 16'(m_axis_tdata[0]));
          compare_field("locked_out", 16'(want.locked_out), 16'(m_axis_tdata[1]));
          compare_field("fan1_rpm", want.fan1_rpm, m_axis_tdata[17:2]);
          compare_field("fan2_rpm", want.fan2_rpm, m_axis_tdata[33:18]);
          compare_field("action", 16'(want.action), 16'(m_axis_tdata[36:34]));
        end
      end
      if (psel && penable && pwrite && pready) begin
        case (reg_e'(paddr[3:2]))
          REG_ON_THR:   cfg.on_thr   = pwdata[15:0];
          REG_OFF_THR:  cfg.off_thr  = pwdata[15:0];
          REG_LOCK_LEN: cfg.lock_len = pwdata[15:0];
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready)
        awaited_reports.push_back(apply_event(s_axis_tuser, s_axis_tdata[1:0]));
    end
    pending_o = awaited_reports.size();
  end

endmodule

// File: tb/fan_tach_rpm_lockout_switch_core_test.sv
// ----------------------------------------------------------------------------
// Fan tach RPM lockout switch: top-level test
// Drives pin samples, timer ticks, control passes and unused codes into the
// block, rewrites the thresholds between phases, and reports the verdict of
// the observer module that predicts and checks every result transaction.
// ----------------------------------------------------------------------------
module fan_tach_rpm_lockout_switch_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  import ftrls_pkg::*;

  // The fourth op code has no meaning in the block; it must change nothing.
  localparam logic [1:0] OP_RESERVED = 2'd3;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        psel          = 1'b0;
  logic        penable       = 1'b0;
  logic        pwrite        = 1'b0;
  logic [3:0]  paddr         = '0;
  logic [31:0] pwdata        = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata  = '0;
  logic [1:0]  s_axis_tuser  = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;

  int unsigned pending;
  int unsigned mismatches;
  int unsigned events_sent = 0;
  // While set, the receiver never stalls and no idle cycles go ahead of events.
  logic        calm = 1'b0;

  fan_tach_rpm_lockout_switch_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  fan_tach_rpm_lockout_switch_core_check u_check (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .pready        (pready),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .pending_o     (pending),
    .mismatches_o  (mismatches)
  );

  // 2 ns clock period.
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // The receiver stalls at random with a chance of 14 percent, except while
  // the long calm stretch is running. Inputs always change on the falling edge.
  always @(negedge clk_i) begin
    m_axis_tready <= calm || ($urandom_range(99) >= 14);
  end

  function automatic logic coin();
    return $urandom_range(1) == 1;
  endfunction

  // Offers one event transaction and returns on the falling edge after it
  // has been accepted. Random idle cycles are inserted ahead of the event,
  // and tvalid stays high between back-to-back transactions.
  task automatic send_event(logic [1:0] op, logic tach1, logic tach2);
    while (!calm && $urandom_range(99) < 14) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {6'b0, tach2, tach1};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    events_sent++;
    @(negedge clk_i);
  endtask

  // Holds the sender back until every outstanding result has been seen,
  // then lets the two-stage pipeline settle.
  task automatic wait_for_results();
    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  // APB write: setup cycle, then the access cycle until pready.
  task automatic write_reg(reg_e idx, int unsigned value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {16'b0, 16'(value)};
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Thresholds are only rewritten once the block has gone quiet.
  task automatic set_thresholds(int unsigned on_rpm, int unsigned off_rpm,
                                int unsigned hold_ticks);
    wait_for_results();
    write_reg(REG_ON_THR, on_rpm);
    write_reg(REG_OFF_THR, off_rpm);
    write_reg(REG_LOCK_LEN, hold_ticks);
  endtask

  // Plays a run of timer ticks. Ahead of each tick go up to 'density' pin
  // samples with random levels, a control pass with the given chance, now
  // and then an unused code, and very rarely a full stop of the sender
  // until the results have drained.
  task automatic run_ticks(int unsigned n, int unsigned density, int unsigned ctrl_pct);
    repeat (n) begin
      repeat ($urandom_range(density)) send_event(OP_SAMPLE, coin(), coin());
      if ($urandom_range(99) < ctrl_pct) send_event(OP_CONTROL, coin(), coin());
      if ($urandom_range(99) < 2) send_event(OP_RESERVED, coin(), coin());
      if ($urandom_range(299) == 0) wait_for_results();
      send_event(OP_TICK, coin(), coin());
    end
  endtask

  // Hard limit on the run time, far beyond the slowest legal run.
  initial begin
    #400_000;
    $display("end of test: mismatches");
    $finish;
  end

  initial begin
    int unsigned random_start;
    int unsigned phase;
    int unsigned on_rpm;

    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed opening. The reset lockout is in force throughout, so every
    // control pass here can only report the lockout.
    set_thresholds(0, 16'hFFFF, 0);
    send_event(OP_RESERVED, 1'b1, 1'b1);  // unused code changes nothing
    send_event(OP_SAMPLE, 1'b1, 1'b1);    // rising edge on both fans
    send_event(OP_SAMPLE, 1'b1, 1'b1);    // level held high, no edge
    send_event(OP_SAMPLE, 1'b0, 1'b0);
    send_event(OP_SAMPLE, 1'b1, 1'b0);    // edge on fan 1 only
    send_event(OP_SAMPLE, 1'b0, 1'b1);    // edge on fan 2 only
    send_event(OP_CONTROL, 1'b0, 1'b0);   // pass during the reset lockout
    send_event(OP_TICK, 1'b1, 1'b1);
    send_event(OP_RESERVED, 1'b0, 1'b0);
    send_event(OP_CONTROL, 1'b1, 1'b1);

    // Run past tick 1200 so that the reset lockout expires; control passes
    // straddle the exact tick at which it ends. The first part of the run is
    // the long stretch with no receiver stalls and no idle cycles ahead of events.
    set_thresholds(2000, 1000, 5);
    calm = 1'b1;
    run_ticks(300, 0, 5);
    calm = 1'b0;
    run_ticks(910, 0, 5);

    // Random phases: each picks a threshold setting and plays one window of
    // varying edge density, so the RPM lands on both sides of the
    // thresholds. The settings cycle through ordinary hysteresis, the
    // flip-on-every-pass extreme, crossed thresholds with long lockouts,
    // and very short lockouts.
    random_start = events_sent;
    phase = 0;
    while (events_sent - random_start < 420) begin
      case (phase % 4)
        0: begin
          on_rpm = $urandom_range(6000);
          set_thresholds(on_rpm, $urandom_range(on_rpm), $urandom_range(40));
        end
        1: set_thresholds(0, 16'hFFFF, 0);
        2: set_thresholds($urandom_range(9000), $urandom_range(9000),
                          $urandom_range(200, 1));
        default: set_thresholds($urandom_range(9000), $urandom_range(9000),
                                $urandom_range(3));
      endcase
      run_ticks(WINDOW_LENGTH_DEF, $urandom_range(4), $urandom_range(12, 2));
      phase++;
    end

    // Top-end settings: nothing can ever switch, whatever the RPM.
    set_thresholds(16'hFFFF, 0, 16'hFFFF);
    run_ticks(WINDOW_LENGTH_DEF, 1, 10);

    wait_for_results();
    repeat (8) @(negedge clk_i);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
